[src/ktr_pkg.sv]
package ktr_pkg;

    localparam int NUM_KEYS = 256;
    localparam int KEY_AW   = $clog2(NUM_KEYS);
    localparam int IDX_W    = 8;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int Q_DEPTH  = 2;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    localparam logic [IDX_W-1:0] LAST_KEY_RESET = 8'hff;
    localparam logic [CFG_W-1:0] DELAY_RESET    = 16'd300;
    localparam logic [CFG_W-1:0] RATE_RESET     = 16'd30;

    // configuration register indexes
    localparam logic REG_REPEAT_DELAY = 1'b0;
    localparam logic REG_REPEAT_RATE  = 1'b1;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_HELD     = 2'd1,
        PH_REPEAT   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_IGNORE  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_SAMPLE  = 2'd3
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EXEC = 1'b1
    } back_state_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [KEY_AW-1:0]   addr;
        logic [IDX_W-1:0]    key;
        logic [TIME_W-1:0]   now;
        logic [IDX_W-1:0]    new_last_key;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] repeat_delay;
        logic [CFG_W-1:0] repeat_rate;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[src/ktr_front.sv]
module ktr_front
    import ktr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                mode,
    input  logic [IDX_W-1:0]    key_index,
    input  logic                key_pressed,
    input  logic [TIME_W-1:0]   now,
    input  logic [IDX_W-1:0]    new_last_key,
    input  logic                q_full,
    output logic                hold_valid,
    output logic                push,
    output cmd_t                cmd
);

    logic [IDX_W+KEY_AW-1:0] idx_ext;
    logic                    hold_valid_reg;
    cmd_t                    cmd_reg;
    cmd_t                    cmd_next;

    assign idx_ext = (IDX_W+KEY_AW)'(key_index);

    // sort the word into the action the back end will take
    always_comb
    begin
        cmd_next.addr         = idx_ext[KEY_AW-1:0];
        cmd_next.key          = key_index;
        cmd_next.now          = now;
        cmd_next.new_last_key = new_last_key;
        if (mode)
        begin
            cmd_next.kind = CMD_SET;
        end
        else if (idx_ext >= (IDX_W+KEY_AW)'(NUM_KEYS))
        begin
            cmd_next.kind = CMD_IGNORE;
        end
        else if (!key_pressed)
        begin
            cmd_next.kind = CMD_RELEASE;
        end
        else
        begin
            cmd_next.kind = CMD_SAMPLE;
        end
    end

    assign push       = hold_valid_reg && !q_full;
    assign hold_valid = hold_valid_reg;
    assign cmd        = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

[src/ktr_queue.sv]
module ktr_queue
    import ktr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output logic    full,
    output logic    empty
);

    cmd_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    assign full  = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[src/ktr_back.sv]
module ktr_back
    import ktr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                q_empty,
    input  cmd_t                q_head,
    output logic                pop,
    output logic                back_busy,
    output logic                done,
    output logic                key_released,
    output logic                key_event,
    output logic [IDX_W-1:0]    last_key
);

    localparam int ENTRY_W = 2 + TIME_W;

    logic [ENTRY_W-1:0] mem [NUM_KEYS];
    logic               valid_reg [NUM_KEYS];

    back_state_t        state_reg;
    back_state_t        state_next;
    cmd_t               cmd_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_valid_reg;

    logic               done_reg;
    logic               done_next;
    logic               released_reg;
    logic               released_next;
    logic               event_reg;
    logic               event_next;
    logic [IDX_W-1:0]   last_key_reg;
    logic [IDX_W-1:0]   last_key_next;

    logic               mem_we;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               valid_set;
    logic               valid_clr;
    phase_t             phase;
    logic [TIME_W-1:0]  deadline;
    logic               passed;

    // a key with no valid bit is released: never pressed since reset, or released since
    assign phase    = rd_valid_reg ? phase_t'(rd_data_reg[ENTRY_W-1:TIME_W]) : PH_RELEASED;
    assign deadline = rd_data_reg[TIME_W-1:0];
    assign passed   = (deadline < cmd_reg.now);

    always_comb
    begin
        state_next    = state_reg;
        pop           = 1'b0;
        done_next     = 1'b0;
        released_next = released_reg;
        event_next    = event_reg;
        last_key_next = last_key_reg;
        mem_we        = 1'b0;
        mem_wdata     = rd_data_reg;
        valid_set     = 1'b0;
        valid_clr     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next    = BK_IDLE;
                done_next     = 1'b1;
                released_next = 1'b0;
                event_next    = 1'b0;
                case (cmd_reg.kind)
                    CMD_SET:
                    begin
                        last_key_next = cmd_reg.new_last_key;
                    end
                    CMD_IGNORE:
                    begin
                        released_next = 1'b1;
                    end
                    CMD_RELEASE:
                    begin
                        released_next = 1'b1;
                        valid_clr     = 1'b1;
                    end
                    CMD_SAMPLE:
                    begin
                        case (phase)
                            PH_RELEASED:
                            begin
                                mem_we        = 1'b1;
                                mem_wdata     = {PH_HELD,
                                                 cmd_reg.now + TIME_W'(cfg.repeat_delay)};
                                valid_set     = 1'b1;
                                event_next    = 1'b1;
                                last_key_next = cmd_reg.key;
                            end
                            PH_HELD, PH_REPEAT:
                            begin
                                // held key past deadline enters repeat and fires at once
                                if (passed)
                                begin
                                    mem_we        = 1'b1;
                                    mem_wdata     = {PH_REPEAT,
                                                     deadline + TIME_W'(cfg.repeat_rate)};
                                    event_next    = 1'b1;
                                    last_key_next = cmd_reg.key;
                                end
                            end
                            default:
                            begin
                                mem_we = 1'b0;
                            end
                        endcase
                    end
                    default:
                    begin
                        released_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            done_reg     <= 1'b0;
            released_reg <= 1'b0;
            event_reg    <= 1'b0;
            last_key_reg <= LAST_KEY_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            released_reg <= released_next;
            event_reg    <= event_next;
            last_key_reg <= last_key_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (valid_set)
        begin
            valid_reg[cmd_reg.addr] <= 1'b1;
        end
        else if (valid_clr)
        begin
            valid_reg[cmd_reg.addr] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg      <= q_head;
            rd_data_reg  <= mem[q_head.addr];
            rd_valid_reg <= valid_reg[q_head.addr];
        end
        if (mem_we)
        begin
            mem[cmd_reg.addr] <= mem_wdata;
        end
    end

    assign back_busy    = (state_reg != BK_IDLE);
    assign done         = done_reg;
    assign key_released = released_reg;
    assign key_event    = event_reg;
    assign last_key     = last_key_reg;

endmodule

[src/key_typematic_repeat.sv]
// a taken word passes the front register, the queue and the back end table read and update;
// done is registered together with the table update
// a new word is taken only once the last is through: busy covers the front register,
// the queue and the back end, and drops in the cycle that shows done
// reset: every key released, last key 255, delay 300, rate 30; no clearing pass
// results are shown for one cycle under done and cannot be stalled
module key_typematic_repeat
    import ktr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                mode,
    input  logic [IDX_W-1:0]    key_index,
    input  logic                key_pressed,
    input  logic [TIME_W-1:0]   now,
    input  logic [IDX_W-1:0]    new_last_key,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output logic                done,
    output logic                key_released,
    output logic                key_event,
    output logic [IDX_W-1:0]    last_key
);

    cfg_t    cfg_reg;
    logic    accept;
    logic    front_valid;
    q_stat_t q_stat;
    cmd_t    front_cmd;
    cmd_t    q_head;
    logic    pop;
    logic    back_busy;

    assign accept = start && !busy;
    assign busy   = front_valid || !q_stat.empty || back_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_delay <= DELAY_RESET;
            cfg_reg.repeat_rate  <= RATE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_REPEAT_DELAY: cfg_reg.repeat_delay <= cfg_data;
                REG_REPEAT_RATE:  cfg_reg.repeat_rate  <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    ktr_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (mode),
        .key_index    (key_index),
        .key_pressed  (key_pressed),
        .now          (now),
        .new_last_key (new_last_key),
        .q_full       (q_stat.full),
        .hold_valid   (front_valid),
        .push         (q_stat.push),
        .cmd          (front_cmd)
    );

    ktr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_stat.push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (q_head),
        .full     (q_stat.full),
        .empty    (q_stat.empty)
    );

    ktr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_stat.empty),
        .q_head       (q_head),
        .pop          (pop),
        .back_busy    (back_busy),
        .done         (done),
        .key_released (key_released),
        .key_event    (key_event),
        .last_key     (last_key)
    );

    // a taken word keeps the block busy until its result is out
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accepting a word");

    // only one word in flight: the pipe is empty when its result shows
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while work still in flight");

    a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(back_busy))
        else $error("result strobe without back end execution");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.push && q_stat.full))
        else $error("push into full queue");

endmodule

[dv/key_typematic_repeat_check.sv]
module key_typematic_repeat_check
    import ktr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                mode,
    input  logic [IDX_W-1:0]    key_index,
    input  logic                key_pressed,
    input  logic [TIME_W-1:0]   now,
    input  logic [IDX_W-1:0]    new_last_key,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                done,
    input  logic                key_released,
    input  logic                key_event,
    input  logic [IDX_W-1:0]    last_key,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               released;
        logic               fired;
        logic [IDX_W-1:0]   latest;
    } key_report_t;

    phase_t             phase_tab    [NUM_KEYS];
    logic [TIME_W-1:0]  deadline_tab [NUM_KEYS];
    logic [IDX_W-1:0]   last_key_q;
    cfg_t               cfg_q;
    key_report_t        expected_reports [$];
    int                 mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    // one word of the typematic engine against the local copy of the key tables
    function automatic key_report_t typematic_step(input logic m, input logic [IDX_W-1:0] idx,
            input logic down, input logic [TIME_W-1:0] t, input logic [IDX_W-1:0] nk);
        key_report_t r;
        phase_t      ph;
        r = '0;
        if (m)
            last_key_q = nk;
        else if (int'(idx) >= NUM_KEYS)
            r.released = 1'b1;
        else if (!down)
        begin
            phase_tab[idx] = PH_RELEASED;
            r.released = 1'b1;
        end
        else
        begin
            ph = phase_tab[idx];
            if (ph == PH_RELEASED)
            begin
                last_key_q        = idx;
                phase_tab[idx]    = PH_HELD;
                deadline_tab[idx] = t + cfg_q.repeat_delay;
                r.fired           = 1'b1;
            end
            else
            begin
                // held key whose deadline has passed turns into repeat in this same step
                if (ph == PH_HELD && deadline_tab[idx] < t)
                begin
                    ph             = PH_REPEAT;
                    phase_tab[idx] = PH_REPEAT;
                end
                if (ph == PH_REPEAT && deadline_tab[idx] < t)
                begin
                    last_key_q        = idx;
                    deadline_tab[idx] = deadline_tab[idx] + cfg_q.repeat_rate;
                    r.fired           = 1'b1;
                end
            end
        end
        r.latest = last_key_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_report_t seen;
        key_report_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                phase_tab[k]    = PH_RELEASED;
                deadline_tab[k] = '0;
            end
            last_key_q = LAST_KEY_RESET;
            cfg_q      = '{repeat_delay: DELAY_RESET, repeat_rate: RATE_RESET};
            expected_reports.delete();
            pending <= 0;
        end
        else
        begin
            // results first: a word taken on this edge cannot be the one reported
            if (done)
            begin
                seen = {key_released, key_event, last_key};
                if (expected_reports.size() == 0)
                    report_mismatch($sformatf("unexpected word: released %0b event %0b last 0x%0h",
                        seen.released, seen.fired, seen.latest));
                else
                begin
                    want = expected_reports.pop_front();
                    if (seen.released !== want.released)
                        report_mismatch($sformatf("key_released: got %0b, want %0b",
                            seen.released, want.released));
                    if (seen.fired !== want.fired)
                        report_mismatch($sformatf("key_event: got %0b, want %0b",
                            seen.fired, want.fired));
                    if (seen.latest !== want.latest)
                        report_mismatch($sformatf("last_key: got 0x%0h, want 0x%0h",
                            seen.latest, want.latest));
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_REPEAT_DELAY)
                    cfg_q.repeat_delay = cfg_data;
                else
                    cfg_q.repeat_rate = cfg_data;
            end
            if (start && !busy)
                expected_reports.push_back(typematic_step(mode, key_index, key_pressed, now,
                    new_last_key));
            pending <= expected_reports.size();
        end
    end

endmodule

[dv/key_typematic_repeat_test.sv]
module key_typematic_repeat_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ktr_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int POOL_SIZE   = 6;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic               mode         = 1'b0;
    logic [IDX_W-1:0]   key_index    = '0;
    logic               key_pressed  = 1'b0;
    logic [TIME_W-1:0]  now          = '0;
    logic [IDX_W-1:0]   new_last_key = '0;
    logic               cfg_wr_en    = 1'b0;
    logic               cfg_index    = REG_REPEAT_DELAY;
    logic [CFG_W-1:0]   cfg_data     = '0;
    logic               done;
    logic               key_released;
    logic               key_event;
    logic [IDX_W-1:0]   last_key;

    int                 fail_count;
    int                 pending;
    int                 quiet_cycles = 0;
    bit                 idle_on      = 1'b1;
    logic [CFG_W-1:0]   cur_delay    = DELAY_RESET;
    logic [CFG_W-1:0]   cur_rate     = RATE_RESET;

    key_typematic_repeat dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .key_index    (key_index),
        .key_pressed  (key_pressed),
        .now          (now),
        .new_last_key (new_last_key),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .key_released (key_released),
        .key_event    (key_event),
        .last_key     (last_key)
    );

    key_typematic_repeat_check checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .key_index    (key_index),
        .key_pressed  (key_pressed),
        .now          (now),
        .new_last_key (new_last_key),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .key_released (key_released),
        .key_event    (key_event),
        .last_key     (last_key),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // start stays high from one word to the next unless a gap is drawn
    task automatic push_word(input logic m, input logic [IDX_W-1:0] idx, input logic down,
            input logic [TIME_W-1:0] t, input logic [IDX_W-1:0] nk);
        if (idle_on)
        begin
            while ($urandom_range(99) < 37)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start        <= 1'b1;
        mode         <= m;
        key_index    <= idx;
        key_pressed  <= down;
        now          <= t;
        new_last_key <= nk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (busy || pending != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] delay_val, input logic [CFG_W-1:0] rate_val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_REPEAT_DELAY;
        cfg_data  <= delay_val;
        @(posedge clk);
        cfg_index <= REG_REPEAT_RATE;
        cfg_data  <= rate_val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_delay = delay_val;
        cur_rate  = rate_val;
    endtask

    // mostly a few keys held down while time moves on, some set words and stray samples
    task automatic run_phase(input int n_words, input logic [TIME_W-1:0] t0);
        logic [IDX_W-1:0]   pool [POOL_SIZE];
        logic [TIME_W-1:0]  t;
        int                 span;
        int                 pick;
        t = t0;
        foreach (pool[i])
            pool[i] = IDX_W'($urandom_range(NUM_KEYS - 1));
        span = ((int'(cur_rate) > int'(cur_delay) / 4) ? int'(cur_rate) : int'(cur_delay) / 4)
            / 3 + 2;
        repeat (n_words)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                push_word(1'b1, IDX_W'($urandom), 1'($urandom), $urandom, IDX_W'($urandom));
            else if (pick < 10)
                push_word(1'b0, IDX_W'($urandom), 1'($urandom), $urandom, IDX_W'($urandom));
            else
            begin
                t = t + $urandom_range(span);
                push_word(1'b0, pool[$urandom_range(POOL_SIZE - 1)], $urandom_range(99) < 85, t,
                    IDX_W'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: delay 300, rate 30
        push_word(1'b0, 8'h00, 1'b0, 32'h0000_0000, 8'h00);
        push_word(1'b1, 8'hff, 1'b1, 32'hffff_ffff, 8'h00);
        push_word(1'b1, 8'h00, 1'b0, 32'h0000_0000, 8'hff);
        push_word(1'b0, 8'hff, 1'b1, 32'd100, 8'h00);
        push_word(1'b0, 8'hff, 1'b1, 32'd400, 8'h00);
        push_word(1'b0, 8'hff, 1'b1, 32'd401, 8'h00);
        push_word(1'b0, 8'hff, 1'b1, 32'd430, 8'h00);
        push_word(1'b0, 8'hff, 1'b1, 32'd500, 8'h00);
        push_word(1'b0, 8'hff, 1'b0, 32'd500, 8'h00);
        // deadline wraps past the top of the time range
        push_word(1'b0, 8'h00, 1'b1, 32'hffff_ff00, 8'h00);
        push_word(1'b0, 8'h00, 1'b1, 32'hffff_ff80, 8'h00);
        push_word(1'b0, 8'h00, 1'b1, 32'hffff_ffff, 8'h00);
        push_word(1'b0, 8'h55, 1'b1, 32'haaaa_aaaa, 8'h00);
        push_word(1'b0, 8'haa, 1'b1, 32'h5555_5555, 8'h00);
        push_word(1'b0, 8'h55, 1'b1, 32'h0000_0001, 8'h00);

        // zero delay: a fresh press must not repeat in its own step
        set_config(16'h0000, 16'h0000);
        push_word(1'b0, 8'd7, 1'b1, 32'd1000, 8'h00);
        push_word(1'b0, 8'd7, 1'b1, 32'd1000, 8'h00);
        push_word(1'b0, 8'd7, 1'b1, 32'd1001, 8'h00);
        push_word(1'b0, 8'd7, 1'b1, 32'd1001, 8'h00);

        set_config(16'hffff, 16'hffff);
        push_word(1'b0, 8'd128, 1'b1, 32'hffff_0000, 8'h00);
        push_word(1'b0, 8'd128, 1'b1, 32'hffff_ffff, 8'h00);
        push_word(1'b0, 8'd129, 1'b1, 32'hffff_0001, 8'h00);
        push_word(1'b0, 8'd129, 1'b1, 32'd5, 8'h00);
        push_word(1'b1, 8'h5a, 1'b1, 32'h1234_5678, 8'ha5);

        set_config(DELAY_RESET, RATE_RESET);
        run_phase(200, $urandom);
        set_config(16'h0000, 16'h0000);
        run_phase(200, $urandom);
        set_config(16'hffff, 16'hffff);
        run_phase(200, 32'hfffe_0000);
        idle_on = 1'b0;
        set_config(CFG_W'($urandom), CFG_W'($urandom));
        run_phase(200, $urandom);
        idle_on = 1'b1;
        set_config(CFG_W'($urandom_range(63)), CFG_W'($urandom_range(63)));
        run_phase(200, $urandom);
        set_config(CFG_W'($urandom), CFG_W'($urandom));
        run_phase(200, $urandom);

        drain();
        repeat (8)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
